// ===== rtl/core/mlbm_pkg.sv =====
`timescale 1ns / 1ps

package mlbm_pkg;

  // Command codes carried with each input item.
  typedef enum logic [2:0] {
    OP_MIDI         = 3'd0,
    OP_LEARN_PARAM  = 3'd1,
    OP_LEARN_ACTION = 3'd2,
    OP_CANCEL_LEARN = 3'd3,
    OP_CLEAR_SLOT   = 3'd4
  } op_e;

  // Learn state.
  typedef enum logic [1:0] {
    LEARN_NONE   = 2'd0,
    LEARN_PARAM  = 2'd1,
    LEARN_ACTION = 2'd2
  } learn_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  // Configuration register indexes.
  localparam logic CFG_PARAM_MASK  = 1'b0;
  localparam logic CFG_ACTION_MASK = 1'b1;

  // MIDI status constants.
  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
  localparam logic [3:0] TYPE_CC       = 4'hB;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [1:0] LEN_FULL      = 2'd3;

  // Number of slots that have a receiver mask bit.
  localparam int MaskBits = 16;

  // Contents of one binding slot (the valid bit is kept in flip-flops).
  typedef struct packed {
    logic       is_note;
    logic [3:0] channel;
    logic [6:0] number;
  } slot_entry_t;

endpackage

// ===== rtl/core/midi_learn_binding_mapper.sv =====
`timescale 1ns / 1ps

// MIDI learn binding mapper.
// Input items arrive on the s_axis channel: tuser carries the command
// (MIDI message, learn parameter, learn action, cancel learn, clear slot)
// and tdata the message bytes and the target slot. Results leave on the
// m_axis channel, one transfer per firing slot in ascending slot order;
// tlast marks the final result of an input item.
// Learn, cancel and clear commands, and messages that are ignored or bound
// by a learn, complete on acceptance and give no result. A message to be
// dispatched walks the slot table stored in a memory with a registered read,
// one slot a cycle while the output does not stall; the next item is accepted
// once the walk is over.
// The last match found is held back one step so that tlast can be set on it.
// When the receiver stalls, the walk pauses on the next match while the output
// register is full; nothing is lost. Reset clears all bindings (valid bits in
// flip-flops), the learn state and both receiver masks.
// The receiver masks are written through the cfg port; the user must write
// them only while the block is idle, which the block itself does not enforce.

module midi_learn_binding_mapper #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] msg_length, [9:2] status_byte, [17:10] data_one, [25:18] data_two,
  // [29:26] target_slot, [31:30] zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] op
  input  logic [2:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] fired_slot, [10:4] cc_value, [15:11] zero
  output logic [15:0] m_axis_tdata,
  // [0] fire_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // Input field extraction.
  logic [1:0] in_len;
  logic [7:0] in_status;
  logic [6:0] in_num;
  logic [6:0] in_val;
  logic [3:0] in_target;
  assign in_len    = s_axis_tdata[1:0];
  assign in_status = s_axis_tdata[9:2];
  assign in_num    = s_axis_tdata[16:10];
  assign in_val    = s_axis_tdata[24:18];
  assign in_target = s_axis_tdata[29:26];

  // Registers.
  mlbm_pkg::state_e       state_q, state_d;
  logic [15:0]            pmask_q, amask_q;
  logic [NUM_SLOTS-1:0]   slot_valid_q, slot_valid_d;
  mlbm_pkg::learn_e       learn_mode_q, learn_mode_d;
  logic [SW-1:0]          learn_slot_q, learn_slot_d;
  logic                   msg_note_q, msg_note_d;
  logic [3:0]             msg_ch_q, msg_ch_d;
  logic [6:0]             msg_num_q, msg_num_d;
  logic [6:0]             msg_val_q, msg_val_d;
  logic [CW-1:0]          iss_cnt_q, iss_cnt_d;
  logic                   e_vld_q, e_vld_d;
  logic [SW-1:0]          e_idx_q, e_idx_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [SW-1:0]          pend_idx_q, pend_idx_d;
  logic                   out_vld_q, out_vld_d;
  logic [3:0]             out_slot_q, out_slot_d;
  logic                   out_kind_q, out_kind_d;
  logic [6:0]             out_val_q, out_val_d;
  logic                   out_last_q, out_last_d;

  // Memory port signals.
  logic                   mem_we;
  logic [SW-1:0]          mem_waddr;
  mlbm_pkg::slot_entry_t  mem_wdata;
  logic                   mem_re;
  mlbm_pkg::slot_entry_t  mem_rdata;

  mlbm_slot_mem #(
    .NUM_SLOTS(NUM_SLOTS),
    .SW       (SW)
  ) u_slot_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(iss_cnt_q[SW-1:0]),
    .rdata_o(mem_rdata)
  );

  // Receiver masks widened to the slot count; slots past the mask never fire.
  logic [NUM_SLOTS-1:0] pmask_ext, amask_ext;
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pmask_ext[i] = (i < mlbm_pkg::MaskBits) ? pmask_q[i % mlbm_pkg::MaskBits] : 1'b0;
      amask_ext[i] = (i < mlbm_pkg::MaskBits) ? amask_q[i % mlbm_pkg::MaskBits] : 1'b0;
    end
  end

  // Target slot range check and index.
  logic [SW+3:0] tgt_ext;
  logic [SW-1:0] tgt_idx;
  logic          tgt_ok;
  assign tgt_ext = {{SW{1'b0}}, in_target};
  assign tgt_idx = tgt_ext[SW-1:0];
  assign tgt_ok  = 32'(in_target) < NUM_SLOTS;

  // Message decode.
  logic in_acc, is_msg, is_cc, is_note_on;
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign is_msg     = (s_axis_tuser == mlbm_pkg::OP_MIDI) && (in_len == mlbm_pkg::LEN_FULL)
                      && (in_status < mlbm_pkg::STATUS_SYSTEM);
  assign is_cc      = is_msg && (in_status[7:4] == mlbm_pkg::TYPE_CC);
  assign is_note_on = is_msg && (in_status[7:4] == mlbm_pkg::TYPE_NOTE_ON) && (in_val != 7'd0);

  // Slot compare at the evaluation stage.
  logic match, out_free, stall, advance, iss_more;
  logic [SW+3:0] pend_ext;
  assign out_free = !out_vld_q || m_axis_tready;
  assign match    = e_vld_q && slot_valid_q[e_idx_q]
                    && (mem_rdata.is_note == msg_note_q)
                    && (mem_rdata.channel == msg_ch_q)
                    && (mem_rdata.number == msg_num_q)
                    && (msg_note_q ? amask_ext[e_idx_q] : pmask_ext[e_idx_q]);
  assign stall    = match && pend_vld_q && !out_free;
  assign advance  = (state_q == mlbm_pkg::ST_SCAN) && !stall;
  assign iss_more = iss_cnt_q < CW'(NUM_SLOTS);
  assign mem_re   = advance && iss_more;
  assign pend_ext = {4'b0, pend_idx_q};

  assign s_axis_tready = (state_q == mlbm_pkg::ST_IDLE);

  // Control and datapath next state.
  always_comb begin
    state_d      = state_q;
    slot_valid_d = slot_valid_q;
    learn_mode_d = learn_mode_q;
    learn_slot_d = learn_slot_q;
    msg_note_d   = msg_note_q;
    msg_ch_d     = msg_ch_q;
    msg_num_d    = msg_num_q;
    msg_val_d    = msg_val_q;
    iss_cnt_d    = iss_cnt_q;
    e_vld_d      = e_vld_q;
    e_idx_d      = e_idx_q;
    pend_vld_d   = pend_vld_q;
    pend_idx_d   = pend_idx_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_slot_d   = out_slot_q;
    out_kind_d   = out_kind_q;
    out_val_d    = out_val_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = tgt_idx;
    mem_wdata    = '0;

    unique case (state_q)
      mlbm_pkg::ST_IDLE: begin
        if (in_acc) begin
          // Commands and learn binding complete in this cycle.
          priority if (s_axis_tuser == mlbm_pkg::OP_LEARN_PARAM
                       || s_axis_tuser == mlbm_pkg::OP_LEARN_ACTION) begin
            if (tgt_ok) begin
              learn_mode_d = (s_axis_tuser == mlbm_pkg::OP_LEARN_PARAM)
                             ? mlbm_pkg::LEARN_PARAM : mlbm_pkg::LEARN_ACTION;
              learn_slot_d = tgt_idx;
            end
          end else if (s_axis_tuser == mlbm_pkg::OP_CANCEL_LEARN) begin
            learn_mode_d = mlbm_pkg::LEARN_NONE;
            learn_slot_d = '0;
          end else if (s_axis_tuser == mlbm_pkg::OP_CLEAR_SLOT) begin
            if (tgt_ok) begin
              mem_we                = 1'b1;
              slot_valid_d[tgt_idx] = 1'b0;
            end
          end else if ((is_cc && learn_mode_q == mlbm_pkg::LEARN_PARAM)
                       || (is_note_on && learn_mode_q == mlbm_pkg::LEARN_ACTION)) begin
            mem_we                     = 1'b1;
            mem_waddr                  = learn_slot_q;
            mem_wdata.is_note          = is_note_on;
            mem_wdata.channel          = in_status[3:0];
            mem_wdata.number           = in_num;
            slot_valid_d[learn_slot_q] = 1'b1;
            learn_mode_d               = mlbm_pkg::LEARN_NONE;
            learn_slot_d               = '0;
          end else if (is_cc || is_note_on) begin
            // Dispatch: start walking the slot table.
            msg_note_d = is_note_on;
            msg_ch_d   = in_status[3:0];
            msg_num_d  = in_num;
            msg_val_d  = in_val;
            iss_cnt_d  = '0;
            e_vld_d    = 1'b0;
            pend_vld_d = 1'b0;
            state_d    = mlbm_pkg::ST_SCAN;
          end else begin
            state_d = mlbm_pkg::ST_IDLE;
          end
        end
      end

      mlbm_pkg::ST_SCAN: begin
        if (!iss_more && !e_vld_q) begin
          // Walk finished: send the held match as the last of the run.
          if (!pend_vld_q) begin
            state_d = mlbm_pkg::ST_IDLE;
          end else if (out_free) begin
            out_vld_d  = 1'b1;
            out_slot_d = pend_ext[3:0];
            out_kind_d = msg_note_q;
            out_val_d  = msg_note_q ? 7'd0 : msg_val_q;
            out_last_d = 1'b1;
            pend_vld_d = 1'b0;
            state_d    = mlbm_pkg::ST_IDLE;
          end
        end else if (advance) begin
          e_vld_d = iss_more;
          e_idx_d = iss_cnt_q[SW-1:0];
          if (iss_more) begin
            iss_cnt_d = iss_cnt_q + CW'(1);
          end
          if (match) begin
            // A newer match proves the held one is not last.
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_slot_d = pend_ext[3:0];
              out_kind_d = msg_note_q;
              out_val_d  = msg_note_q ? 7'd0 : msg_val_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = e_idx_q;
          end
        end
      end

      default: begin
        state_d = mlbm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlbm_pkg::ST_IDLE;
      slot_valid_q <= '0;
      learn_mode_q <= mlbm_pkg::LEARN_NONE;
      learn_slot_q <= '0;
      iss_cnt_q    <= '0;
      e_vld_q      <= 1'b0;
      pend_vld_q   <= 1'b0;
      out_vld_q    <= 1'b0;
      pmask_q      <= '0;
      amask_q      <= '0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      learn_mode_q <= learn_mode_d;
      learn_slot_q <= learn_slot_d;
      iss_cnt_q    <= iss_cnt_d;
      e_vld_q      <= e_vld_d;
      pend_vld_q   <= pend_vld_d;
      out_vld_q    <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mlbm_pkg::CFG_PARAM_MASK:  pmask_q <= cfg_data_i;
          mlbm_pkg::CFG_ACTION_MASK: amask_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    msg_note_q <= msg_note_d;
    msg_ch_q   <= msg_ch_d;
    msg_num_q  <= msg_num_d;
    msg_val_q  <= msg_val_d;
    e_idx_q    <= e_idx_d;
    pend_idx_q <= pend_idx_d;
    out_slot_q <= out_slot_d;
    out_kind_q <= out_kind_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  // Result channel.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_val_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/mlbm_slot_mem.sv =====
`timescale 1ns / 1ps

module mlbm_slot_mem #(
  parameter int NUM_SLOTS = 16,
  parameter int SW        = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [SW-1:0]        waddr_i,
  input  mlbm_pkg::slot_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [SW-1:0]        raddr_i,
  output mlbm_pkg::slot_entry_t rdata_o
);

  mlbm_pkg::slot_entry_t mem_q [NUM_SLOTS];
  mlbm_pkg::slot_entry_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
